// File: rtl/line_receive_ring_buffer_defines.svh
// Assertion macros shared by the receive ring buffer RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef LINE_RECEIVE_RING_BUFFER_DEFINES_SVH
`define LINE_RECEIVE_RING_BUFFER_DEFINES_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define LRRB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition must never be seen at a clock edge outside reset.
`define LRRB_ASSERT_NEVER(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define LRRB_ASSERT(lbl, clk, rst_n, prop, msg)
`define LRRB_ASSERT_NEVER(lbl, clk, rst_n, prop, msg)
`endif

`endif

// File: rtl/lrrb_pkg.sv
// Package for the receive ring buffer: field widths, codes and payload types.
// Depends on nothing; imported by every module of the block but lrrb_ram.
`default_nettype none

package lrrb_pkg;

  localparam int RING_DEPTH_DEF = 64;

  localparam int ACTION_W = 3;
  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 7;
  localparam int COUNT_W  = 6;
  localparam int STATUS_W = 2;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // Carriage return ends a line after reset.
  localparam logic [BYTE_W-1:0] DELIM_RESET = 8'd13;

  // Register index as seen in paddr[2].
  localparam logic REG_LINE_DELIM = 1'b0;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH      = 3'd0,
    ACT_READ      = 3'd1,
    ACT_PEEK      = 3'd2,
    ACT_READ_LINE = 3'd3,
    ACT_PEEK_LINE = 3'd4
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_TOO_LONG = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_EMIT,
    S_STAT
  } state_e;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [BYTE_W-1:0]   byte_in;
    logic [LEN_W-1:0]    length;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   data_byte;
    logic [COUNT_W-1:0]  count;
    logic [STATUS_W-1:0] status;
    logic                last;
  } out_item_t;

endpackage

`default_nettype wire

// File: rtl/lrrb_ram.sv
// Generic single-port synchronous RAM with a registered read.
// Depends on nothing; used for the byte store of the ring buffer.
`default_nettype none

module lrrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] addr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // The read data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/lrrb_cfg.sv
// APB register bank of the ring buffer: holds the line delimiter.
// Depends on lrrb_pkg.
`default_nettype none

module lrrb_cfg (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [lrrb_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [lrrb_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [lrrb_pkg::APB_DATA_W-1:0] prdata,
  output logic                                 pready,
  output logic      [lrrb_pkg::BYTE_W-1:0]     delim_o
);

  import lrrb_pkg::*;

  logic [BYTE_W-1:0] delim_q, delim_d;
  logic              wr_en;
  logic              sel_delim;

  assign pready    = 1'b1;
  assign sel_delim = (paddr[2] == REG_LINE_DELIM);
  assign wr_en     = psel && penable && pwrite && pready;

  always_comb begin
    delim_d = delim_q;
    if (wr_en && sel_delim) begin
      delim_d = pwdata[BYTE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q <= DELIM_RESET;
    end else begin
      delim_q <= delim_d;
    end
  end

  assign prdata  = sel_delim ? APB_DATA_W'(delim_q) : '0;
  assign delim_o = delim_q;

endmodule

`default_nettype wire

// File: rtl/lrrb_ctrl.sv
// Sequencer of the ring buffer: pointers, line scan, byte emission, output register.
// Depends on lrrb_pkg and the assertion macros; drives the byte store RAM.
`default_nettype none
`include "line_receive_ring_buffer_defines.svh"

module lrrb_ctrl #(
  parameter int RING_DEPTH = lrrb_pkg::RING_DEPTH_DEF,
  localparam int PTR_W = $clog2(RING_DEPTH)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire lrrb_pkg::in_item_t          in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output lrrb_pkg::out_item_t              out_data_o,
  input  wire logic [lrrb_pkg::BYTE_W-1:0] delim_i,
  output logic                             ram_we_o,
  output logic                             ram_re_o,
  output logic      [PTR_W-1:0]            ram_addr_o,
  output logic      [lrrb_pkg::BYTE_W-1:0] ram_wdata_o,
  input  wire logic [lrrb_pkg::BYTE_W-1:0] ram_rdata_i
);

  import lrrb_pkg::*;

  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(RING_DEPTH - 1);
  localparam logic [PTR_W:0]   DEPTH_P  = (PTR_W+1)'(RING_DEPTH);
  localparam logic [LEN_W-1:0] DEPTH_L  = LEN_W'(RING_DEPTH);

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == LAST_IDX) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  state_e             state_q, state_d;
  logic [PTR_W-1:0]   wp_q, wp_d, rp_q, rp_d, ptr_q, ptr_d;
  logic [COUNT_W-1:0] cnt_q, cnt_d, rem_q, rem_d, ecnt_q, ecnt_d, scnt_q, scnt_d;
  logic [LEN_W-1:0]   lim_q, lim_d;
  logic               line_q, line_d, consume_q, consume_d;
  status_e            stat_q, stat_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, out_d;

  logic [PTR_W:0]     used;
  logic               accept, out_free, is_delim, lim_hit, rem_one;
  logic [COUNT_W-1:0] cnt_inc;
  logic [PTR_W-1:0]   ptr_nxt;
  logic               dec_stat, dec_emit, dec_scan;
  status_e            dec_code;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign used = (wp_q >= rp_q) ? ({1'b0, wp_q} - {1'b0, rp_q})
                               : ({1'b0, wp_q} + DEPTH_P - {1'b0, rp_q});

  assign is_delim = (ram_rdata_i == delim_i);
  assign lim_hit  = line_q && (LEN_W'(cnt_q) >= lim_q);
  assign cnt_inc  = cnt_q + 1'b1;
  assign ptr_nxt  = wrap_inc(ptr_q);
  assign rem_one  = (rem_q == COUNT_W'(1));

  // Request decode for the item offered in idle.
  always_comb begin
    dec_stat = 1'b0;
    dec_emit = 1'b0;
    dec_scan = 1'b0;
    dec_code = ST_EMPTY;
    unique case (in_data_i.action)
      ACT_PUSH: begin
      end
      ACT_READ, ACT_PEEK: begin
        if (in_data_i.length == '0) begin
          dec_stat = 1'b1;
        end else if (in_data_i.length >= DEPTH_L) begin
          dec_stat = 1'b1;
          dec_code = ST_TOO_LONG;
        end else if (in_data_i.length > LEN_W'(used)) begin
          dec_stat = 1'b1;
        end else begin
          dec_emit = 1'b1;
        end
      end
      ACT_READ_LINE: begin
        if (in_data_i.length == '0) begin
          dec_stat = 1'b1;
        end else if (in_data_i.length >= DEPTH_L) begin
          dec_stat = 1'b1;
          dec_code = ST_TOO_LONG;
        end else if (wp_q == rp_q) begin
          dec_stat = 1'b1;
        end else begin
          dec_scan = 1'b1;
        end
      end
      ACT_PEEK_LINE: begin
        if (wp_q == rp_q) begin
          dec_stat = 1'b1;
        end else begin
          dec_scan = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          priority if (dec_stat) begin
            state_d = S_STAT;
          end else if (dec_emit) begin
            state_d = S_EMIT;
          end else if (dec_scan) begin
            state_d = S_CHECK;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_CHECK: begin
        priority if (lim_hit) begin
          state_d = S_STAT;
        end else if (is_delim) begin
          state_d = line_q ? S_EMIT : S_STAT;
        end else if (ptr_nxt == wp_q) begin
          state_d = S_STAT;
        end else begin
          state_d = S_CHECK;
        end
      end
      S_EMIT: begin
        if (out_free && rem_one) begin
          state_d = S_IDLE;
        end
      end
      S_STAT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath, RAM access and output register loads.
  always_comb begin
    wp_d        = wp_q;
    rp_d        = rp_q;
    ptr_d       = ptr_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    ecnt_d      = ecnt_q;
    scnt_d      = scnt_q;
    lim_d       = lim_q;
    line_d      = line_q;
    consume_d   = consume_q;
    stat_d      = stat_q;
    ram_we_o    = 1'b0;
    ram_re_o    = 1'b0;
    ram_addr_o  = ptr_q;
    ram_wdata_o = in_data_i.byte_in;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_data_i.action == ACT_PUSH) begin
            ram_we_o   = 1'b1;
            ram_addr_o = wp_q;
            wp_d       = wrap_inc(wp_q);
          end
          stat_d    = dec_code;
          scnt_d    = '0;
          ptr_d     = rp_q;
          cnt_d     = '0;
          lim_d     = in_data_i.length;
          rem_d     = in_data_i.length[COUNT_W-1:0];
          ecnt_d    = in_data_i.length[COUNT_W-1:0];
          consume_d = (in_data_i.action == ACT_READ);
          line_d    = (in_data_i.action == ACT_READ_LINE);
          if (dec_emit || dec_scan) begin
            ram_re_o   = 1'b1;
            ram_addr_o = rp_q;
          end
        end
      end
      S_CHECK: begin
        stat_d = ST_EMPTY;
        scnt_d = '0;
        if (!lim_hit) begin
          if (is_delim) begin
            if (line_q) begin
              // Line found: replay it from the read pointer and consume it.
              ram_re_o   = 1'b1;
              ram_addr_o = rp_q;
              ptr_d      = rp_q;
              rem_d      = cnt_inc;
              ecnt_d     = cnt_inc;
              consume_d  = 1'b1;
            end else begin
              stat_d = ST_OK;
              scnt_d = cnt_inc;
            end
          end else if (ptr_nxt != wp_q) begin
            ram_re_o   = 1'b1;
            ram_addr_o = ptr_nxt;
            ptr_d      = ptr_nxt;
            cnt_d      = cnt_inc;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d     = 1'b1;
          out_d.data_byte = ram_rdata_i;
          out_d.count     = ecnt_q;
          out_d.status    = ST_OK;
          out_d.last      = rem_one;
          if (rem_one) begin
            if (consume_q) begin
              rp_d = ptr_nxt;
            end
          end else begin
            ram_re_o   = 1'b1;
            ram_addr_o = ptr_nxt;
            ptr_d      = ptr_nxt;
            rem_d      = rem_q - 1'b1;
          end
        end
      end
      S_STAT: begin
        if (out_free) begin
          out_valid_d     = 1'b1;
          out_d.data_byte = '0;
          out_d.count     = scnt_q;
          out_d.status    = stat_q;
          out_d.last      = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wp_q        <= '0;
      rp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q     <= ptr_d;
    cnt_q     <= cnt_d;
    rem_q     <= rem_d;
    ecnt_q    <= ecnt_d;
    scnt_q    <= scnt_d;
    lim_q     <= lim_d;
    line_q    <= line_d;
    consume_q <= consume_d;
    stat_q    <= stat_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `LRRB_ASSERT(a_ptr_range, clk_i, rst_ni, (wp_q <= LAST_IDX) && (rp_q <= LAST_IDX), "pointer out of range")
  `LRRB_ASSERT(a_emit_rem, clk_i, rst_ni, (state_q == S_EMIT) |-> (rem_q != '0), "emit with no bytes left")
  `LRRB_ASSERT_NEVER(a_scan_head, clk_i, rst_ni, (state_q == S_CHECK) && (ptr_q == wp_q), "scan reached write pointer")
  `LRRB_ASSERT(a_rp_move, clk_i, rst_ni, !$stable(rp_q) |-> ($past(state_q) == S_EMIT), "read pointer moved outside emission")

endmodule

`default_nettype wire

// File: rtl/line_receive_ring_buffer.sv
// Top level of the receive byte ring buffer with line reads.
// Depends on lrrb_pkg, lrrb_cfg, lrrb_ctrl and lrrb_ram.
//
// Usage: requests enter on the in channel (valid/ready) as an in_item_t with
// an action, a byte and a length; results leave on the out channel as
// out_item_t transactions, the final one of each request flagged by last.
// A push gives no result and leaves the sequencer idle; pushes can follow each
// other in every cycle. A read or peek of N bytes loads its first byte into
// the output register in the emit state once that register is free and then
// one byte per cycle while the receiver is ready, so it holds off the input
// until its last byte is in the output register. Line actions first scan
// the ring from the read pointer one byte per cycle through the single RAM
// port until the delimiter, the write pointer or a read line's length limit
// is met; a read line then replays the line byte by byte. Error answers
// leave from the status state entered on acceptance, a peek line answer from
// the status state entered after its scan. A new request is taken as soon as
// the last transaction of the previous one sits in the output register. When
// the receiver stalls, that register holds its transaction and the sequencer
// waits. Reset empties the ring (both pointers zero), clears the output valid
// and sets the delimiter to carriage return; only pushed bytes are ever read.
`default_nettype none

module line_receive_ring_buffer #(
  parameter int RING_DEPTH = lrrb_pkg::RING_DEPTH_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire lrrb_pkg::in_item_t              in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output lrrb_pkg::out_item_t                  out_data_o,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [lrrb_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [lrrb_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [lrrb_pkg::APB_DATA_W-1:0] prdata,
  output logic                                 pready
);

  import lrrb_pkg::*;

  localparam int PTR_W = $clog2(RING_DEPTH);

  logic [BYTE_W-1:0] delim;
  logic              ram_we, ram_re;
  logic [PTR_W-1:0]  ram_addr;
  logic [BYTE_W-1:0] ram_wdata, ram_rdata;

  // Delimiter register behind the APB port.
  lrrb_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .delim_o (delim)
  );

  // Sequencer: owns the pointers and the output register.
  lrrb_ctrl #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .delim_i     (delim),
    .ram_we_o    (ram_we),
    .ram_re_o    (ram_re),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata),
    .ram_rdata_i (ram_rdata)
  );

  // Byte store; reads and writes never fall in the same cycle.
  lrrb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RING_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire

// File: test/tb.sv
// Testbench for line_receive_ring_buffer: requests go in through the valid/ready
// channel, and every result transaction is checked against a local ring model.
// Depends on lrrb_pkg and the line_receive_ring_buffer RTL only.
`timescale 1ns / 100ps

module tb;
  import lrrb_pkg::*;

  localparam int DEPTH          = RING_DEPTH_DEF;
  localparam int HALF_PERIOD    = 4;
  // A line read scans and then replays up to the whole ring.
  localparam int SETTLE_CYCLES  = 2 * DEPTH + 16;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_REQUESTS = 30;
  localparam int MAX_REPORTS    = 40;

  localparam logic [ACTION_W-1:0]   ACT_SPARE_FIRST = 3'd5;
  localparam logic [ACTION_W-1:0]   ACT_SPARE_LAST  = 3'd7;
  localparam logic [APB_ADDR_W-1:0] DELIM_ADDR      = {REG_LINE_DELIM, 2'b00};

  localparam out_item_t R_EMPTY = '{8'h00, 6'd0, ST_EMPTY, 1'b1};
  localparam out_item_t R_LONG  = '{8'h00, 6'd0, ST_TOO_LONG, 1'b1};
  localparam out_item_t R_NONE  = '0;

  typedef logic [$clog2(DEPTH)-1:0] ring_ptr_t;

  typedef struct packed {
    in_item_t  req;
    logic      typed;
    out_item_t reply;
  } step_row_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  in_item_t              in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_item_t             out_data_o;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [APB_ADDR_W-1:0] paddr       = '0;
  logic [APB_DATA_W-1:0] pwdata      = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // Local copy of the ring: store, pointers and the delimiter register.
  logic [BYTE_W-1:0] ring_mem [DEPTH];
  ring_ptr_t         ring_wr    = '0;
  ring_ptr_t         ring_rd    = '0;
  logic [BYTE_W-1:0] line_delim = DELIM_RESET;

  out_item_t replies_due [$];

  int errors         = 0;
  int requests_taken = 0;
  int quiet_cycles   = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_req       = 1'b0;

  // Directed requests. A typed reply is used only where it is obvious from the
  // request alone; other rows are checked against the ring model.
  step_row_t directed_steps [23] = '{
    // Zero length, oversized length and empty ring errors, right after reset.
    '{'{ACT_READ,      8'h00, 7'd0},   1'b1, R_EMPTY},
    '{'{ACT_PEEK,      8'h00, 7'd127}, 1'b1, R_LONG},
    '{'{ACT_READ,      8'h00, 7'd64},  1'b1, R_LONG},
    '{'{ACT_READ_LINE, 8'h00, 7'd0},   1'b1, R_EMPTY},
    '{'{ACT_READ_LINE, 8'h00, 7'd127}, 1'b1, R_LONG},
    '{'{ACT_PEEK_LINE, 8'h00, 7'd0},   1'b1, R_EMPTY},
    '{'{ACT_PEEK,      8'h00, 7'd1},   1'b1, R_EMPTY},
    // Unused action codes are dropped without a reply.
    '{'{ACT_SPARE_FIRST, 8'hFF, 7'd127}, 1'b0, R_NONE},
    '{'{ACT_SPARE_LAST,  8'h00, 7'd0},   1'b0, R_NONE},
    // One short line followed by a stray byte.
    '{'{ACT_PUSH,      8'h00,       7'd0}, 1'b0, R_NONE},
    '{'{ACT_PUSH,      8'hFF,       7'd0}, 1'b0, R_NONE},
    '{'{ACT_PUSH,      8'h41,       7'd0}, 1'b0, R_NONE},
    '{'{ACT_PUSH,      DELIM_RESET, 7'd0}, 1'b0, R_NONE},
    '{'{ACT_PUSH,      8'h55,       7'd0}, 1'b0, R_NONE},
    '{'{ACT_PEEK_LINE, 8'h00,       7'd0}, 1'b0, R_NONE},
    // Limit runs out one byte before the delimiter.
    '{'{ACT_READ_LINE, 8'h00, 7'd3},  1'b0, R_NONE},
    '{'{ACT_PEEK,      8'h00, 7'd5},  1'b0, R_NONE},
    '{'{ACT_PEEK,      8'h00, 7'd6},  1'b0, R_NONE},
    '{'{ACT_READ_LINE, 8'h00, 7'd63}, 1'b0, R_NONE},
    // Only the stray byte is left: no delimiter in the ring.
    '{'{ACT_READ_LINE, 8'h00, 7'd1},  1'b0, R_NONE},
    '{'{ACT_PEEK_LINE, 8'h00, 7'd0},  1'b0, R_NONE},
    '{'{ACT_READ,      8'h00, 7'd1},  1'b0, R_NONE},
    '{'{ACT_READ,      8'h00, 7'd63}, 1'b1, R_EMPTY}
  };

  line_receive_ring_buffer #(
    .RING_DEPTH(DEPTH)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  function automatic ring_ptr_t step_ptr(input ring_ptr_t p);
    return (int'(p) == DEPTH - 1) ? '0 : ring_ptr_t'(int'(p) + 1);
  endfunction

  function automatic int ring_fill();
    return (int'(ring_wr) + DEPTH - int'(ring_rd)) % DEPTH;
  endfunction

  function automatic out_item_t reply(input logic [BYTE_W-1:0] data, input int cnt,
                                      input status_e st, input logic fin);
    out_item_t r;
    r.data_byte = data;
    r.count     = COUNT_W'(cnt);
    r.status    = st;
    r.last      = fin;
    return r;
  endfunction

  function automatic in_item_t req(input logic [ACTION_W-1:0] act,
                                   input logic [BYTE_W-1:0] data,
                                   input logic [LEN_W-1:0] len);
    in_item_t it;
    it.action  = act;
    it.byte_in = data;
    it.length  = len;
    return it;
  endfunction

  // Random byte that does not end a line under the current delimiter.
  function automatic logic [BYTE_W-1:0] plain_byte();
    logic [BYTE_W-1:0] b;
    do b = BYTE_W'($urandom_range(255)); while (b == line_delim);
    return b;
  endfunction

  // Applies one accepted request to the ring copy and queues the replies it causes.
  task automatic apply_to_ring(input in_item_t it);
    int        n;
    int        cnt;
    int        i;
    ring_ptr_t pos;
    ring_ptr_t src;
    logic      found;
    n     = int'(it.length);
    pos   = ring_rd;
    cnt   = 0;
    found = 1'b0;
    case (it.action)
      ACT_PUSH: begin
        ring_mem[ring_wr] = it.byte_in;
        ring_wr = step_ptr(ring_wr);
      end
      ACT_READ, ACT_PEEK: begin
        if (n >= DEPTH) begin
          replies_due.push_back(R_LONG);
        end else if (n == 0 || n > ring_fill()) begin
          replies_due.push_back(R_EMPTY);
        end else begin
          for (i = 0; i < n; i++) begin
            replies_due.push_back(reply(ring_mem[pos], n, ST_OK, i + 1 == n));
            pos = step_ptr(pos);
          end
          if (it.action == ACT_READ) ring_rd = pos;
        end
      end
      ACT_READ_LINE: begin
        if (n >= DEPTH) begin
          replies_due.push_back(R_LONG);
        end else if (n == 0) begin
          replies_due.push_back(R_EMPTY);
        end else begin
          // The limit counts the delimiter itself.
          while (pos != ring_wr && cnt < n && !found) begin
            found = (ring_mem[pos] == line_delim);
            cnt++;
            pos = step_ptr(pos);
          end
          if (found) begin
            src = ring_rd;
            for (i = 0; i < cnt; i++) begin
              replies_due.push_back(reply(ring_mem[src], cnt, ST_OK, i + 1 == cnt));
              src = step_ptr(src);
            end
            ring_rd = pos;
          end else begin
            replies_due.push_back(R_EMPTY);
          end
        end
      end
      ACT_PEEK_LINE: begin
        while (pos != ring_wr && !found) begin
          found = (ring_mem[pos] == line_delim);
          cnt++;
          pos = step_ptr(pos);
        end
        replies_due.push_back(found ? reply('0, cnt, ST_OK, 1'b1) : R_EMPTY);
      end
      default: ;
    endcase
  endtask

  // Offers one request and returns at the falling edge after its transaction.
  // The caller must either offer again or drop valid in that same step.
  task automatic offer(input in_item_t it, input logic typed = 1'b0,
                       input out_item_t fixed = '0);
    int due_before;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    due_before = replies_due.size();
    apply_to_ring(it);
    if (typed) begin
      while (replies_due.size() > due_before) void'(replies_due.pop_back());
      replies_due.push_back(fixed);
    end
    if (it.action <= ACT_PEEK_LINE) requests_taken++;
    @(negedge clk_i);
  endtask

  // Drops valid, waits for every reply and then for a full scan's worth of cycles.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_delimiter(input logic [BYTE_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= DELIM_ADDR;
    pwdata  <= APB_DATA_W'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    line_delim = value;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  // Result side: every transaction is matched against the oldest pending reply.
  always @(posedge clk_i) begin : reply_check
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (replies_due.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: transaction with none expected, actual data %0d count %0d status %0d last %0d",
                   $time, out_data_o.data_byte, out_data_o.count, out_data_o.status,
                   out_data_o.last);
      end else begin
        want = replies_due.pop_front();
        compare_field("data_byte", want.data_byte, out_data_o.data_byte);
        compare_field("count", want.count, out_data_o.count);
        compare_field("status", want.status, out_data_o.status);
        compare_field("last", want.last, out_data_o.last);
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin : receiver
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: ends the run when neither channel moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int fill;
    int kind;
    int len;
    int goal;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_steps[k])
      offer(directed_steps[k].req, directed_steps[k].typed, directed_steps[k].reply);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          // A line that fills the ring to one short of its depth, read in full.
          fill = ring_fill();
          if (fill != 0) offer(req(ACT_READ, '0, LEN_W'(fill)));
          for (int k = 0; k < DEPTH - 2; k++) offer(req(ACT_PUSH, plain_byte(), '0));
          offer(req(ACT_PUSH, line_delim, '0));
          offer(req(ACT_PEEK_LINE, '0, '0));
          offer(req(ACT_PEEK, '0, LEN_W'(DEPTH - 1)));
          offer(req(ACT_READ_LINE, '0, LEN_W'(DEPTH - 1)));
          // A full depth of pushes with no reads wraps the write pointer onto
          // the read pointer, so the ring reads as empty again.
          for (int k = 0; k < DEPTH; k++)
            offer(req(ACT_PUSH, BYTE_W'($urandom_range(255)), '0));
          offer(req(ACT_PEEK_LINE, '0, '0));
          offer(req(ACT_READ, '0, LEN_W'(1)));
        end
        1: begin
          settle();
          write_delimiter(8'h00);
          send_idle_pct  = 63;
          recv_stall_pct = 0;
        end
        2: begin
          settle();
          write_delimiter(8'hFF);
          send_idle_pct  = 0;
          recv_stall_pct = 63;
        end
        default: begin
          settle();
          write_delimiter(BYTE_W'($urandom_range(1, 254)));
          send_idle_pct  = 28;
          recv_stall_pct = 28;
        end
      endcase

      // Mostly whole lines and reads that fit what is stored, with some noise.
      goal = requests_taken + PHASE_REQUESTS;
      while (requests_taken < goal) begin
        kind = $urandom_range(99);
        fill = ring_fill();
        if (kind < 30 && fill < DEPTH - 14) begin
          len = $urandom_range(1, 12);
          repeat (len) offer(req(ACT_PUSH, plain_byte(), '0));
          offer(req(ACT_PUSH, line_delim, '0));
        end else if (kind < 45) begin
          offer(req(ACT_READ_LINE, '0, LEN_W'($urandom_range(1, DEPTH - 1))));
        end else if (kind < 55) begin
          offer(req(ACT_PEEK_LINE, BYTE_W'($urandom_range(255)), '0));
        end else if (kind < 78 && fill != 0) begin
          offer(req($urandom_range(1) ? ACT_READ : ACT_PEEK, '0,
                    LEN_W'($urandom_range(1, fill))));
        end else if (kind < 90) begin
          offer(req(ACT_PUSH, BYTE_W'($urandom_range(255)), '0));
        end else begin
          offer(req(ACTION_W'($urandom_range(7)), BYTE_W'($urandom_range(255)),
                    LEN_W'($urandom_range(127))));
        end
      end
    end

    // Back to carriage return, then stall the receiver for a long stretch while
    // reads and pushes keep coming, so the block backs up into its input.
    settle();
    write_delimiter(DELIM_RESET);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (20) offer(req(ACT_PUSH, BYTE_W'($urandom_range(255)), '0));
    hold_req = 1'b1;
    repeat (6) begin
      offer(req(ACT_READ, '0, LEN_W'(3)));
      offer(req(ACT_PUSH, BYTE_W'($urandom_range(255)), '0));
    end

    settle();
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
